[hdl/trd_pkg.sv]
package trd_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgSkipCount  = 1'b0,
    CfgSkipWindow = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Interrupt status and coordinate byte bit positions.
  localparam int unsigned IrqPenRelBit  = 2;
  localparam int unsigned IrqConvBit    = 3;
  localparam int unsigned CoordInvBit   = 7;

  // Held conversions tolerated before the hold is lifted.
  localparam logic [2:0] MaxHeldSkips = 3'd3;

  // Register reset values.
  localparam logic [3:0]  SkipCountRst  = 4'd1;
  localparam logic [15:0] SkipWindowRst = 16'd20;

endpackage

[hdl/touch_report_debouncer_top.sv]
// Touch report debouncer. Each interrupt event presented on the input channel
// yields exactly one result transaction on the output channel. A new event is
// accepted every clock cycle while the output is not stalled; each event is
// first captured in the input register, then moves into the result register,
// which presents its result on the output until it is taken. The per-event
// path is one 32-bit elapsed-time subtraction and compare plus small flag and
// counter updates. The output register lets the next event enter while a
// result still waits to be taken.
// Configuration registers (skip count, skip window) are written through the
// cfg port, which is always ready, and should be written only while idle.
module touch_report_debouncer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trd_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          status_ok_i,
  input  logic [7:0]                    irq_status_i,
  input  logic                          data_ok_i,
  input  logic [7:0]                    byte0_i,
  input  logic [7:0]                    byte1_i,
  input  logic [7:0]                    byte2_i,
  input  logic [7:0]                    byte3_i,
  input  logic [31:0]                   now_ms_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          release_event_o,
  output logic                          press_event_o,
  output logic [11:0]                   x_out_o,
  output logic [11:0]                   y_out_o,
  output logic                          activity_led_o
);

  // Configuration registers.
  logic [3:0]  skip_count_q;
  logic [15:0] skip_window_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_count_q  <= trd_pkg::SkipCountRst;
      skip_window_q <= trd_pkg::SkipWindowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (trd_pkg::cfg_reg_e'(cfg_index_i))
        trd_pkg::CfgSkipCount:  skip_count_q  <= cfg_data_i[3:0];
        trd_pkg::CfgSkipWindow: skip_window_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Handshake control for the input register and the result register.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_en;
  logic s1_fire;
  logic in_accept;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_en;
  assign in_stall_o = s1_valid_q && !out_en;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (out_en) begin
        out_valid_q <= s1_fire;
      end
    end
  end

  // Input register for the event payload.
  logic        status_ok_q;
  logic [7:0]  irq_status_q;
  logic        data_ok_q;
  logic [7:0]  byte0_q;
  logic [7:0]  byte1_q;
  logic [7:0]  byte2_q;
  logic [7:0]  byte3_q;
  logic [31:0] now_ms_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_ok_q  <= status_ok_i;
      irq_status_q <= irq_status_i;
      data_ok_q    <= data_ok_i;
      byte0_q      <= byte0_i;
      byte1_q      <= byte1_i;
      byte2_q      <= byte2_i;
      byte3_q      <= byte3_i;
      now_ms_q     <= now_ms_i;
    end
  end

  // Report state.
  logic [3:0]  skips_left_q,  skips_left_d;
  logic        hold_q,        hold_d;
  logic        touch_act_q,   touch_act_d;
  logic        first_q,       first_d;
  logic [11:0] held_x_q,      held_x_d;
  logic [11:0] held_y_q,      held_y_d;
  logic        any_valid_q,   any_valid_d;
  logic [2:0]  held_skips_q,  held_skips_d;
  logic [31:0] rel_time_q,    rel_time_d;
  logic        led_q,         led_d;

  // Result values for the current event.
  logic        rel_ev;
  logic        press_ev;
  logic [11:0] x_res;
  logic [11:0] y_res;

  logic        is_rel;
  logic        is_conv;
  logic        coord_ok;
  logic [11:0] x_new;
  logic [11:0] y_new;
  logic [31:0] elapsed;
  logic [2:0]  held_skips_inc;

  assign is_rel   = status_ok_q && irq_status_q[trd_pkg::IrqPenRelBit];
  assign is_conv  = status_ok_q && irq_status_q[trd_pkg::IrqConvBit];
  assign coord_ok = data_ok_q && !byte0_q[trd_pkg::CoordInvBit]
                    && !byte2_q[trd_pkg::CoordInvBit];
  assign x_new    = {byte0_q[3:0], byte1_q};
  assign y_new    = {byte2_q[3:0], byte3_q};

  // Next-state and result logic: release first, then the conversion.
  always_comb begin
    skips_left_d   = skips_left_q;
    hold_d         = hold_q;
    touch_act_d    = touch_act_q;
    first_d        = first_q;
    held_x_d       = held_x_q;
    held_y_d       = held_y_q;
    any_valid_d    = any_valid_q;
    held_skips_d   = held_skips_q;
    rel_time_d     = rel_time_q;
    led_d          = led_q;
    rel_ev         = 1'b0;
    press_ev       = 1'b0;
    x_res          = '0;
    y_res          = '0;
    elapsed        = '0;
    held_skips_inc = held_skips_q;

    if (is_rel) begin
      rel_time_d   = now_ms_q;
      rel_ev       = touch_act_q;
      touch_act_d  = 1'b0;
      skips_left_d = skip_count_q;
      hold_d       = 1'b0;
      first_d      = 1'b1;
      led_d        = 1'b0;
    end

    if (is_conv) begin
      elapsed = now_ms_q - rel_time_d;
      if (first_d && (elapsed < {16'd0, skip_window_q})) begin
        hold_d = 1'b1;
      end
      if (coord_ok) begin
        if (!hold_d) begin
          if (skips_left_d != 4'd0) begin
            skips_left_d = skips_left_d - 4'd1;
            any_valid_d  = 1'b0;
            held_skips_d = 3'd0;
          end else begin
            press_ev    = 1'b1;
            x_res       = first_d ? x_new : held_x_q;
            y_res       = first_d ? y_new : held_y_q;
            touch_act_d = 1'b1;
            any_valid_d = 1'b1;
          end
        end else begin
          // Count held conversions, saturating one past the limit.
          if (held_skips_q <= trd_pkg::MaxHeldSkips) begin
            held_skips_inc = held_skips_q + 3'd1;
          end
          held_skips_d = held_skips_inc;
          if (!any_valid_q && (held_skips_inc > trd_pkg::MaxHeldSkips)) begin
            hold_d = 1'b0;
          end
        end
        held_x_d = x_new;
        held_y_d = y_new;
        first_d  = 1'b0;
        led_d    = 1'b1;
      end
    end
  end

  // State update when an event passes into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skips_left_q <= 4'd1;
      hold_q       <= 1'b0;
      touch_act_q  <= 1'b0;
      first_q      <= 1'b1;
      held_x_q     <= '0;
      held_y_q     <= '0;
      any_valid_q  <= 1'b0;
      held_skips_q <= '0;
      rel_time_q   <= '0;
      led_q        <= 1'b0;
    end else if (s1_fire) begin
      skips_left_q <= skips_left_d;
      hold_q       <= hold_d;
      touch_act_q  <= touch_act_d;
      first_q      <= first_d;
      held_x_q     <= held_x_d;
      held_y_q     <= held_y_d;
      any_valid_q  <= any_valid_d;
      held_skips_q <= held_skips_d;
      rel_time_q   <= rel_time_d;
      led_q        <= led_d;
    end
  end

  // Result register.
  logic        rel_ev_q;
  logic        press_ev_q;
  logic [11:0] x_out_q;
  logic [11:0] y_out_q;
  logic        led_out_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rel_ev_q   <= rel_ev;
      press_ev_q <= press_ev;
      x_out_q    <= x_res;
      y_out_q    <= y_res;
      led_out_q  <= led_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign release_event_o = rel_ev_q;
  assign press_event_o   = press_ev_q;
  assign x_out_o         = x_out_q;
  assign y_out_o         = y_out_q;
  assign activity_led_o  = led_out_q;

  // The held-conversion counter never passes its saturation value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_skips_q <= (trd_pkg::MaxHeldSkips + 3'd1))
    else $error("held conversion counter out of range");

  // A reported press always leaves the activity LED on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && press_event_o |-> activity_led_o)
    else $error("press reported with LED off");

  // Coordinates are zero unless a press is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !press_event_o |-> (x_out_o == 12'd0) && (y_out_o == 12'd0))
    else $error("coordinates without a press");

  // A lone release turns the LED off and arms the first-pair flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && is_rel && !is_conv |=> !led_q && first_q && !touch_act_q)
    else $error("release did not reset report state");

  // A press is only reported while no hold is active in the next state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && press_ev |=> touch_act_q && !hold_q)
    else $error("press reported during hold");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumDirected = 25;

  // One interrupt event as presented on the input channel.
  typedef struct packed {
    logic        status_ok;
    logic [7:0]  irq_status;
    logic        data_ok;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [31:0] now_ms;
  } touch_event_t;

  // One report as seen on the output channel.
  typedef struct packed {
    logic        release_event;
    logic        press_event;
    logic [11:0] x_out;
    logic [11:0] y_out;
    logic        activity_led;
  } touch_report_t;

  // A directed row; the report is used only when pinned is set.
  typedef struct packed {
    touch_event_t  ev;
    logic          pinned;
    touch_report_t rpt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [trd_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [trd_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        status_ok_i = 1'b0;
  logic [7:0]  irq_status_i = '0;
  logic        data_ok_i = 1'b0;
  logic [7:0]  byte0_i = '0;
  logic [7:0]  byte1_i = '0;
  logic [7:0]  byte2_i = '0;
  logic [7:0]  byte3_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        release_event_o;
  logic        press_event_o;
  logic [11:0] x_out_o;
  logic [11:0] y_out_o;
  logic        activity_led_o;

  // Pinned report that travels alongside the current input transaction.
  logic          pin_valid = 1'b0;
  touch_report_t pin_rpt = '0;

  // Debouncer state mirror and its register copies.
  logic [3:0]  win_skip_count;
  logic [15:0] win_ms;
  logic [3:0]  pen_skips_left;
  logic        pen_hold;
  logic        pen_touching;
  logic        pen_fresh;
  logic [11:0] pen_last_x;
  logic [11:0] pen_last_y;
  logic        pen_reported;
  logic [2:0]  pen_held_cnt;
  logic [31:0] pen_release_ms;
  logic        pen_led;

  touch_report_t pending_reports[$];
  dir_row_t      dir_rows[NumDirected];

  int unsigned errors = 0;
  int unsigned events_taken = 0;
  int unsigned presses_seen = 0;
  int unsigned releases_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [31:0] clock_ms = '0;

  touch_report_debouncer_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .status_ok_i     (status_ok_i),
    .irq_status_i    (irq_status_i),
    .data_ok_i       (data_ok_i),
    .byte0_i         (byte0_i),
    .byte1_i         (byte1_i),
    .byte2_i         (byte2_i),
    .byte3_i         (byte3_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .release_event_o (release_event_o),
    .press_event_o   (press_event_o),
    .x_out_o         (x_out_o),
    .y_out_o         (y_out_o),
    .activity_led_o  (activity_led_o)
  );

  always #5 clk = ~clk;

  // Advance the mirrored debouncer by one event and return its report.
  function automatic touch_report_t debounce_event(input touch_event_t ev);
    touch_report_t r;
    logic [11:0]   x;
    logic [11:0]   y;
    logic [31:0]   elapsed;
    r = '0;
    if (ev.status_ok) begin
      // A pen release rearms the skip logic and ends any active touch.
      if (ev.irq_status[trd_pkg::IrqPenRelBit]) begin
        pen_release_ms = ev.now_ms;
        if (pen_touching) begin
          r.release_event = 1'b1;
          pen_touching = 1'b0;
        end
        pen_skips_left = win_skip_count;
        pen_hold = 1'b0;
        pen_fresh = 1'b1;
        pen_led = 1'b0;
      end
      if (ev.irq_status[trd_pkg::IrqConvBit]) begin
        // The window check happens even when the frame is later dropped.
        if (pen_fresh) begin
          elapsed = ev.now_ms - pen_release_ms;
          if (elapsed < {16'h0000, win_ms}) pen_hold = 1'b1;
        end
        if (ev.data_ok && !ev.byte0[trd_pkg::CoordInvBit]
            && !ev.byte2[trd_pkg::CoordInvBit]) begin
          x = {ev.byte0[3:0], ev.byte1};
          y = {ev.byte2[3:0], ev.byte3};
          if (!pen_hold) begin
            if (pen_skips_left != 4'd0) begin
              pen_skips_left = pen_skips_left - 4'd1;
              pen_reported = 1'b0;
              pen_held_cnt = 3'd0;
            end else begin
              if (pen_fresh) begin
                pen_last_x = x;
                pen_last_y = y;
              end
              r.press_event = 1'b1;
              r.x_out = pen_last_x;
              r.y_out = pen_last_y;
              pen_touching = 1'b1;
              pen_reported = 1'b1;
            end
          end else begin
            // Too many held frames with nothing reported lifts the hold.
            if (pen_held_cnt <= trd_pkg::MaxHeldSkips) pen_held_cnt = pen_held_cnt + 3'd1;
            if (!pen_reported && pen_held_cnt > trd_pkg::MaxHeldSkips) pen_hold = 1'b0;
          end
          pen_last_x = x;
          pen_last_y = y;
          pen_fresh = 1'b0;
          pen_led = 1'b1;
        end
      end
    end
    r.activity_led = pen_led;
    return r;
  endfunction

  // Build one random event; time mostly creeps forward, sometimes jumps anywhere.
  function automatic touch_event_t make_event(input logic [7:0] irq_base);
    touch_event_t ev;
    ev.status_ok = ($urandom_range(99) >= 3);
    ev.irq_status = irq_base;
    if ($urandom_range(99) < 20) ev.irq_status = irq_base | (8'($urandom_range(255)) & 8'hF3);
    ev.data_ok = ($urandom_range(99) >= 5);
    ev.byte0 = 8'($urandom_range(255));
    ev.byte1 = 8'($urandom_range(255));
    ev.byte2 = 8'($urandom_range(255));
    ev.byte3 = 8'($urandom_range(255));
    if ($urandom_range(99) >= 6) ev.byte0[trd_pkg::CoordInvBit] = 1'b0;
    if ($urandom_range(99) >= 6) ev.byte2[trd_pkg::CoordInvBit] = 1'b0;
    if ($urandom_range(99) < 2) clock_ms = $urandom;
    else clock_ms = clock_ms + 32'($urandom_range(30));
    ev.now_ms = clock_ms;
    return ev;
  endfunction

  // Present one event and hold it until the transaction completes.
  task automatic send_event(input touch_event_t ev, input logic pinned,
                            input touch_report_t rpt);
    in_valid_i   <= 1'b1;
    status_ok_i  <= ev.status_ok;
    irq_status_i <= ev.irq_status;
    data_ok_i    <= ev.data_ok;
    byte0_i      <= ev.byte0;
    byte1_i      <= ev.byte1;
    byte2_i      <= ev.byte2;
    byte3_i      <= ev.byte3;
    now_ms_i     <= ev.now_ms;
    pin_valid    <= pinned;
    pin_rpt      <= rpt;
    do @(posedge clk); while (in_stall_o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and let every outstanding report arrive.
  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    pin_valid  <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input trd_pkg::cfg_reg_e idx,
                           input logic [trd_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // Random touch sessions: a release followed by a run of conversions, with noise mixed in.
  task automatic run_phase(input int unsigned n_items, input int unsigned send_pct,
                           input int unsigned rx_pct);
    int unsigned  sent;
    int unsigned  len;
    touch_event_t ev;
    send_idle_pct = send_pct;
    stall_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(20, 2);
      for (int k = 0; k < len && sent < n_items; k++) begin
        if (k == 0) ev = make_event(($urandom_range(99) < 25) ? 8'h0C : 8'h04);
        else if ($urandom_range(99) < 10) ev = make_event(8'($urandom_range(255)));
        else ev = make_event(8'h08);
        send_event(ev, 1'b0, '0);
        sent++;
        // Halfway through, let the pipeline run completely dry once.
        if (sent == n_items / 2) wait_for_reports();
      end
    end
    wait_for_reports();
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d reports outstanding.",
               cycle_count, pending_reports.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Checks each output transaction, then tracks register writes and input transactions.
  always @(posedge clk) begin
    touch_report_t got;
    touch_report_t want;
    touch_report_t predicted;
    touch_event_t  ev;
    if (!rst_ni) begin
      win_skip_count = trd_pkg::SkipCountRst;
      win_ms         = trd_pkg::SkipWindowRst;
      pen_skips_left = trd_pkg::SkipCountRst;
      pen_hold       = 1'b0;
      pen_touching   = 1'b0;
      pen_fresh      = 1'b1;
      pen_last_x     = '0;
      pen_last_y     = '0;
      pen_reported   = 1'b0;
      pen_held_cnt   = '0;
      pen_release_ms = '0;
      pen_led        = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{release_event_o, press_event_o, x_out_o, y_out_o, activity_led_o};
        if (got.press_event === 1'b1) presses_seen++;
        if (got.release_event === 1'b1) releases_seen++;
        if (pending_reports.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected report at cycle %0d.", cycle_count);
        end else begin
          want = pending_reports.pop_front();
          if (got.release_event !== want.release_event || got.press_event !== want.press_event
              || got.x_out !== want.x_out || got.y_out !== want.y_out
              || got.activity_led !== want.activity_led) begin
            errors++;
            if (errors <= 10)
              $display({"Report mismatch at cycle %0d: expected rel=%0b press=%0b x=%03h ",
                        "y=%03h led=%0b, got rel=%0b press=%0b x=%03h y=%03h led=%0b"},
                       cycle_count, want.release_event, want.press_event, want.x_out,
                       want.y_out, want.activity_led, got.release_event, got.press_event,
                       got.x_out, got.y_out, got.activity_led);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (trd_pkg::cfg_reg_e'(cfg_index_i))
          trd_pkg::CfgSkipCount:  win_skip_count = cfg_data_i[3:0];
          trd_pkg::CfgSkipWindow: win_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        ev = '{status_ok_i, irq_status_i, data_ok_i, byte0_i, byte1_i, byte2_i, byte3_i,
               now_ms_i};
        predicted = debounce_event(ev);
        pending_reports.push_back(pin_valid ? pin_rpt : predicted);
        events_taken++;
      end
    end
  end

  initial begin
    // Directed events: status failure, window edges, skipping, late reporting,
    // dropped frames, combined release and conversion, hold lifting, time wrap.
    dir_rows[0]  = '{'{1'b0, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF},
                     1'b1, '{1'b0, 1'b0, 12'h000, 12'h000, 1'b0}};
    dir_rows[1]  = '{'{1'b1, 8'h04, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd100},
                     1'b1, '{1'b0, 1'b0, 12'h000, 12'h000, 1'b0}};
    dir_rows[2]  = '{'{1'b1, 8'h08, 1'b1, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 32'd100},
                     1'b1, '{1'b0, 1'b0, 12'h000, 12'h000, 1'b1}};
    dir_rows[3]  = '{'{1'b1, 8'h04, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd1000},
                     1'b1, '{1'b0, 1'b0, 12'h000, 12'h000, 1'b0}};
    dir_rows[4]  = '{'{1'b1, 8'h08, 1'b1, 8'h70, 8'h00, 8'h70, 8'h00, 32'd1020},
                     1'b1, '{1'b0, 1'b0, 12'h000, 12'h000, 1'b1}};
    dir_rows[5]  = '{'{1'b1, 8'h08, 1'b1, 8'h01, 8'h23, 8'h04, 8'h56, 32'd1030},
                     1'b1, '{1'b0, 1'b1, 12'h000, 12'h000, 1'b1}};
    dir_rows[6]  = '{'{1'b1, 8'h08, 1'b1, 8'h80, 8'h11, 8'h02, 8'h22, 32'd1031},
                     1'b1, '{1'b0, 1'b0, 12'h000, 12'h000, 1'b1}};
    dir_rows[7]  = '{'{1'b1, 8'h08, 1'b0, 8'h03, 8'h33, 8'h04, 8'h44, 32'd1032},
                     1'b1, '{1'b0, 1'b0, 12'h000, 12'h000, 1'b1}};
    dir_rows[8]  = '{'{1'b1, 8'h08, 1'b1, 8'h05, 8'h55, 8'h8F, 8'h66, 32'd1033},
                     1'b1, '{1'b0, 1'b0, 12'h000, 12'h000, 1'b1}};
    dir_rows[9]  = '{'{1'b1, 8'h08, 1'b1, 8'h0A, 8'hBC, 8'h0D, 8'hEF, 32'd1034},
                     1'b1, '{1'b0, 1'b1, 12'h123, 12'h456, 1'b1}};
    dir_rows[10] = '{'{1'b1, 8'h0C, 1'b1, 8'h07, 8'h77, 8'h08, 8'h88, 32'd5000},
                     1'b1, '{1'b1, 1'b0, 12'h000, 12'h000, 1'b1}};
    dir_rows[11] = '{'{1'b1, 8'h08, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd5001}, 1'b0, '0};
    dir_rows[12] = '{'{1'b1, 8'h04, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd6000}, 1'b0, '0};
    dir_rows[13] = '{'{1'b1, 8'h08, 1'b1, 8'h02, 8'h46, 8'h03, 8'h57, 32'd6100}, 1'b0, '0};
    dir_rows[14] = '{'{1'b1, 8'h04, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd7000}, 1'b0, '0};
    dir_rows[15] = '{'{1'b1, 8'h08, 1'b1, 8'h01, 8'h01, 8'h02, 8'h02, 32'd7000}, 1'b0, '0};
    dir_rows[16] = '{'{1'b1, 8'h08, 1'b1, 8'h01, 8'h02, 8'h02, 8'h03, 32'd7005}, 1'b0, '0};
    dir_rows[17] = '{'{1'b1, 8'h08, 1'b1, 8'h01, 8'h03, 8'h02, 8'h04, 32'd7010}, 1'b0, '0};
    dir_rows[18] = '{'{1'b1, 8'h08, 1'b1, 8'h01, 8'h04, 8'h02, 8'h05, 32'd7015}, 1'b0, '0};
    dir_rows[19] = '{'{1'b1, 8'h08, 1'b1, 8'h01, 8'h05, 8'h02, 8'h06, 32'd7020}, 1'b0, '0};
    dir_rows[20] = '{'{1'b1, 8'h08, 1'b1, 8'h01, 8'h06, 8'h02, 8'h07, 32'd7025}, 1'b0, '0};
    dir_rows[21] = '{'{1'b1, 8'h04, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFF0},
                     1'b0, '0};
    dir_rows[22] = '{'{1'b1, 8'h08, 1'b1, 8'h0C, 8'hDE, 8'h0E, 8'hF0, 32'h0000_0002},
                     1'b0, '0};
    dir_rows[23] = '{'{1'b1, 8'hF3, 1'b1, 8'h01, 8'h10, 8'h02, 8'h20, 32'd10}, 1'b0, '0};
    dir_rows[24] = '{'{1'b1, 8'h0C, 1'b0, 8'h01, 8'h10, 8'h02, 8'h20, 32'd20}, 1'b0, '0};

    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++)
      send_event(dir_rows[i].ev, dir_rows[i].pinned, dir_rows[i].rpt);
    wait_for_reports();

    // Reset settings, no idling on either side.
    run_phase(350, 0, 0);
    // Lowest settings, sender often idle.
    write_reg(trd_pkg::CfgSkipCount, 16'd0);
    write_reg(trd_pkg::CfgSkipWindow, 16'd0);
    run_phase(350, 57, 0);
    // Highest settings, receiver often stalled.
    write_reg(trd_pkg::CfgSkipCount, 16'd15);
    write_reg(trd_pkg::CfgSkipWindow, 16'hFFFF);
    run_phase(350, 0, 57);
    // Moderate settings, light idling on both sides.
    write_reg(trd_pkg::CfgSkipCount, 16'd3);
    write_reg(trd_pkg::CfgSkipWindow, 16'd40);
    run_phase(350, 7, 7);
    // Random settings; the unused upper bits of the skip count are exercised too.
    write_reg(trd_pkg::CfgSkipCount, 16'($urandom));
    write_reg(trd_pkg::CfgSkipWindow, 16'($urandom_range(100)));
    run_phase(350, 57, 57);

    repeat (8) @(posedge clk);
    errors += pending_reports.size();
    $display("Ran %0d events through five register settings and five idling mixes.",
             events_taken);
    $display("Observed %0d press reports and %0d release reports, %0d errors.",
             presses_seen, releases_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
